[rtl/assert_macros.svh]
// Assertion helpers for the hash engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SHA_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SHA_ASSERT(lbl, clk, rst_n, prop, msg)
`define SHA_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

[rtl/sha_pkg.sv]
package sha_pkg;

    localparam int ROUND_CNT_CAP  = 128;
    localparam int ROUND_CNT_DFLT = 64;
    localparam int BLOCK_BYTES    = 64;
    localparam int LENGTH_POS     = 56;
    localparam int SHA224_LIMIT   = 28;
    localparam int DIGEST_MAX     = 32;
    localparam int FIFO_DEPTH     = 4;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [1:0] CFG_ROUND_COUNT  = 2'd0;
    localparam logic [1:0] CFG_DIGEST_BYTES = 2'd1;

    localparam logic CMD_ABSORB = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_LEN,
        S_ROUND,
        S_ADD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } t_req;

    typedef struct packed {
        logic       we;
        logic [1:0] index;
        logic [7:0] data;
    } t_cfg_wr;

    function automatic logic [31:0] f_rotr(input logic [31:0] x, input int n);
        logic [63:0] d;
        d = {x, x} >> n;
        return d[31:0];
    endfunction

    function automatic logic [31:0] f_bsig0(input logic [31:0] x);
        return f_rotr(x, 2) ^ f_rotr(x, 13) ^ f_rotr(x, 22);
    endfunction

    function automatic logic [31:0] f_bsig1(input logic [31:0] x);
        return f_rotr(x, 6) ^ f_rotr(x, 11) ^ f_rotr(x, 25);
    endfunction

    function automatic logic [31:0] f_ssig0(input logic [31:0] x);
        return f_rotr(x, 7) ^ f_rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] f_ssig1(input logic [31:0] x);
        return f_rotr(x, 17) ^ f_rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [5:0] f_emit_len(input logic [5:0] db);
        return (db > 6'(DIGEST_MAX)) ? 6'(DIGEST_MAX) : db;
    endfunction

    function automatic logic [31:0] f_iv(input logic sel224, input logic [2:0] idx);
        logic [31:0] v;
        v = '0;
        if (sel224) begin
            case (idx)
                3'd0: v = 32'hC1059ED8;
                3'd1: v = 32'h367CD507;
                3'd2: v = 32'h3070DD17;
                3'd3: v = 32'hF70E5939;
                3'd4: v = 32'hFFC00B31;
                3'd5: v = 32'h68581511;
                3'd6: v = 32'h64F98FA7;
                default: v = 32'hBEFA4FA4;
            endcase
        end else begin
            case (idx)
                3'd0: v = 32'h6A09E667;
                3'd1: v = 32'hBB67AE85;
                3'd2: v = 32'h3C6EF372;
                3'd3: v = 32'hA54FF53A;
                3'd4: v = 32'h510E527F;
                3'd5: v = 32'h9B05688C;
                3'd6: v = 32'h1F83D9AB;
                default: v = 32'h5BE0CD19;
            endcase
        end
        return v;
    endfunction

    function automatic logic [31:0] f_round_k(input logic [6:0] i);
        logic [31:0] k;
        case (i)
            7'd0:   k = 32'h428A2F98;  7'd1:   k = 32'h71374491;
            7'd2:   k = 32'hB5C0FBCF;  7'd3:   k = 32'hE9B5DBA5;
            7'd4:   k = 32'h3956C25B;  7'd5:   k = 32'h59F111F1;
            7'd6:   k = 32'h923F82A4;  7'd7:   k = 32'hAB1C5ED5;
            7'd8:   k = 32'hD807AA98;  7'd9:   k = 32'h12835B01;
            7'd10:  k = 32'h243185BE;  7'd11:  k = 32'h550C7DC3;
            7'd12:  k = 32'h72BE5D74;  7'd13:  k = 32'h80DEB1FE;
            7'd14:  k = 32'h9BDC06A7;  7'd15:  k = 32'hC19BF174;
            7'd16:  k = 32'hE49B69C1;  7'd17:  k = 32'hEFBE4786;
            7'd18:  k = 32'h0FC19DC6;  7'd19:  k = 32'h240CA1CC;
            7'd20:  k = 32'h2DE92C6F;  7'd21:  k = 32'h4A7484AA;
            7'd22:  k = 32'h5CB0A9DC;  7'd23:  k = 32'h76F988DA;
            7'd24:  k = 32'h983E5152;  7'd25:  k = 32'hA831C66D;
            7'd26:  k = 32'hB00327C8;  7'd27:  k = 32'hBF597FC7;
            7'd28:  k = 32'hC6E00BF3;  7'd29:  k = 32'hD5A79147;
            7'd30:  k = 32'h06CA6351;  7'd31:  k = 32'h14292967;
            7'd32:  k = 32'h27B70A85;  7'd33:  k = 32'h2E1B2138;
            7'd34:  k = 32'h4D2C6DFC;  7'd35:  k = 32'h53380D13;
            7'd36:  k = 32'h650A7354;  7'd37:  k = 32'h766A0ABB;
            7'd38:  k = 32'h81C2C92E;  7'd39:  k = 32'h92722C85;
            7'd40:  k = 32'hA2BFE8A1;  7'd41:  k = 32'hA81A664B;
            7'd42:  k = 32'hC24B8B70;  7'd43:  k = 32'hC76C51A3;
            7'd44:  k = 32'hD192E819;  7'd45:  k = 32'hD6990624;
            7'd46:  k = 32'hF40E3585;  7'd47:  k = 32'h106AA070;
            7'd48:  k = 32'h19A4C116;  7'd49:  k = 32'h1E376C08;
            7'd50:  k = 32'h2748774C;  7'd51:  k = 32'h34B0BCB5;
            7'd52:  k = 32'h391C0CB3;  7'd53:  k = 32'h4ED8AA4A;
            7'd54:  k = 32'h5B9CCA4F;  7'd55:  k = 32'h682E6FF3;
            7'd56:  k = 32'h748F82EE;  7'd57:  k = 32'h78A5636F;
            7'd58:  k = 32'h84C87814;  7'd59:  k = 32'h8CC70208;
            7'd60:  k = 32'h90BEFFFA;  7'd61:  k = 32'hA4506CEB;
            7'd62:  k = 32'hBEF9A3F7;  7'd63:  k = 32'hC67178F2;
            7'd64:  k = 32'hCA273ECE;  7'd65:  k = 32'hD186B8C7;
            7'd66:  k = 32'hEADA7DD6;  7'd67:  k = 32'hF57D4F7F;
            7'd68:  k = 32'h06F067AA;  7'd69:  k = 32'h0A637DC5;
            7'd70:  k = 32'h113F9804;  7'd71:  k = 32'h1B710B35;
            7'd72:  k = 32'h28DB77F5;  7'd73:  k = 32'h32CAAB7B;
            7'd74:  k = 32'h3C9EBE0A;  7'd75:  k = 32'h431D67C4;
            7'd76:  k = 32'h4CC5D4BE;  7'd77:  k = 32'h597F299C;
            7'd78:  k = 32'h5FCB6FAB;  7'd79:  k = 32'h6C44198C;
            7'd80:  k = 32'h7BA0EA2D;  7'd81:  k = 32'h7EABF2D0;
            7'd82:  k = 32'h8DBE8D03;  7'd83:  k = 32'h90BB1721;
            7'd84:  k = 32'h99A2AD45;  7'd85:  k = 32'h9F86E289;
            7'd86:  k = 32'hA84C4472;  7'd87:  k = 32'hB3DF34FC;
            7'd88:  k = 32'hB99BB8D7;  7'd89:  k = 32'hBC76CBAB;
            7'd90:  k = 32'hC226A69A;  7'd91:  k = 32'hD304F19A;
            7'd92:  k = 32'hDE1BE20A;  7'd93:  k = 32'hE39BB437;
            7'd94:  k = 32'hEE84927C;  7'd95:  k = 32'hF3EDD277;
            7'd96:  k = 32'hFBFDFE53;  7'd97:  k = 32'h0BEE2C7A;
            7'd98:  k = 32'h0E90181C;  7'd99:  k = 32'h25F57204;
            7'd100: k = 32'h2DA45582;  7'd101: k = 32'h3A52C34C;
            7'd102: k = 32'h41DC0172;  7'd103: k = 32'h495796FC;
            7'd104: k = 32'h4BD31FC6;  7'd105: k = 32'h533CDE21;
            7'd106: k = 32'h5F7ABFE3;  7'd107: k = 32'h66C206B3;
            7'd108: k = 32'h6DFCC6BC;  7'd109: k = 32'h7062F20F;
            7'd110: k = 32'h778D5127;  7'd111: k = 32'h7EABA3CC;
            7'd112: k = 32'h8363ECCC;  7'd113: k = 32'h85BE1C25;
            7'd114: k = 32'h93C04028;  7'd115: k = 32'h9F4A205F;
            7'd116: k = 32'hA1953565;  7'd117: k = 32'hA627BB0F;
            7'd118: k = 32'hACFA8089;  7'd119: k = 32'hB3C29B23;
            7'd120: k = 32'hB602F6FA;  7'd121: k = 32'hC36CEE0A;
            7'd122: k = 32'hC7DC81EE;  7'd123: k = 32'hCE7B8471;
            7'd124: k = 32'hD740288C;  7'd125: k = 32'hE21DBA7A;
            7'd126: k = 32'hEABBFF66;  default: k = 32'hF56A9E60;
        endcase
        return k;
    endfunction

endpackage

[rtl/sha_req_fifo.sv]
module sha_req_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sha_pkg::t_req i_req,
    output logic          o_not_full,
    input  logic          i_pop,
    output logic          o_req_valid,
    output sha_pkg::t_req o_req
);

    localparam int PW = $clog2(sha_pkg::FIFO_DEPTH);

    sha_pkg::t_req r_mem [sha_pkg::FIFO_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [PW:0]   r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_not_full  = (r_cnt != (PW+1)'(sha_pkg::FIFO_DEPTH));
    assign o_req_valid = (r_cnt != '0);
    assign o_req       = r_mem[r_rd];
    assign w_push      = i_push && o_not_full;
    assign w_pop       = i_pop && o_req_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_req;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + PW'(1);
            if (w_pop)  r_rd <= r_rd + PW'(1);
            r_cnt <= r_cnt + (PW+1)'(w_push) - (PW+1)'(w_pop);
        end
    end

endmodule

[rtl/sha_core.sv]
module sha_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  sha_pkg::t_req    i_req,
    output logic             o_pop,
    input  sha_pkg::t_cfg_wr i_cfg,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_digest_byte,
    output logic [4:0]       o_byte_index,
    output logic             o_last_byte,
    output logic             o_length_overflow
);

    sha_pkg::t_state r_state, n_state;
    logic [7:0]   r_rc, n_rc;
    logic [5:0]   r_db, n_db;
    logic [5:0]   r_fill, n_fill;
    logic [63:0]  r_bitlen, n_bitlen;
    logic         r_ovf, n_ovf;
    logic         r_final, n_final;
    logic         r_ret_pad, n_ret_pad;
    logic [7:0]   r_round, n_round;
    logic [5:0]   r_oidx, n_oidx;
    logic [511:0] r_win, n_win;
    logic [31:0]  r_chain [8];
    logic [31:0]  n_chain [8];
    logic [31:0]  r_v [8];
    logic [31:0]  n_v [8];
    logic         r_ov, n_ov;
    logic [7:0]   r_obyte, n_obyte;
    logic [4:0]   r_oindex, n_oindex;
    logic         r_olast, n_olast;
    logic         r_oovf, n_oovf;

    logic [7:0]  w_eff;
    logic [5:0]  w_el;
    logic [5:0]  w_new_el;
    logic [31:0] w_t1;
    logic [31:0] w_t2;
    logic [31:0] w_wnew;
    logic [31:0] w_word;
    logic [64:0] w_bitsum;
    logic [2:0]  w_lidx;

    assign o_valid           = r_ov;
    assign o_digest_byte     = r_obyte;
    assign o_byte_index      = r_oindex;
    assign o_last_byte       = r_olast;
    assign o_length_overflow = r_oovf;

    assign w_eff = (r_rc == 8'd0) ? 8'(sha_pkg::ROUND_CNT_DFLT) :
                   (r_rc > 8'(sha_pkg::ROUND_CNT_CAP)) ? 8'(sha_pkg::ROUND_CNT_CAP) : r_rc;
    assign w_el     = sha_pkg::f_emit_len(r_db);
    assign w_new_el = sha_pkg::f_emit_len(i_cfg.data[5:0]);
    assign w_t1 = r_v[7] + sha_pkg::f_bsig1(r_v[4]) + (r_v[6] ^ (r_v[4] & (r_v[5] ^ r_v[6])))
                + sha_pkg::f_round_k(r_round[6:0]) + r_win[511:480];
    assign w_t2 = sha_pkg::f_bsig0(r_v[0]) + ((r_v[0] & r_v[1]) | (r_v[2] & (r_v[0] | r_v[1])));
    assign w_wnew = sha_pkg::f_ssig1(r_win[63:32]) + r_win[223:192]
                  + sha_pkg::f_ssig0(r_win[479:448]) + r_win[511:480];
    assign w_word   = r_chain[r_oidx[4:2]];
    assign w_bitsum = {1'b0, r_bitlen} + 65'd8;
    assign w_lidx   = r_fill[2:0];

    always_comb begin
        n_state   = r_state;
        n_rc      = r_rc;
        n_db      = r_db;
        n_fill    = r_fill;
        n_bitlen  = r_bitlen;
        n_ovf     = r_ovf;
        n_final   = r_final;
        n_ret_pad = r_ret_pad;
        n_round   = r_round;
        n_oidx    = r_oidx;
        n_win     = r_win;
        n_chain   = r_chain;
        n_v       = r_v;
        n_ov      = r_ov && !i_ready;
        n_obyte   = r_obyte;
        n_oindex  = r_oindex;
        n_olast   = r_olast;
        n_oovf    = r_oovf;
        o_pop     = 1'b0;

        case (r_state)
            sha_pkg::S_IDLE: begin
                if (i_req_valid) begin
                    o_pop  = 1'b1;
                    n_fill = r_fill + 6'd1;
                    n_v    = r_chain;
                    n_round = '0;
                    n_final = 1'b0;
                    if (i_req.command == sha_pkg::CMD_ABSORB) begin
                        n_win    = {r_win[503:0], i_req.data_byte};
                        n_bitlen = w_bitsum[63:0];
                        if (w_bitsum[64]) n_ovf = 1'b1;
                        n_ret_pad = 1'b0;
                        if (r_fill == 6'(sha_pkg::BLOCK_BYTES - 1)) n_state = sha_pkg::S_ROUND;
                    end else begin
                        n_win     = {r_win[503:0], sha_pkg::PAD_BYTE};
                        n_ret_pad = 1'b1;
                        if (r_fill == 6'(sha_pkg::BLOCK_BYTES - 1)) n_state = sha_pkg::S_ROUND;
                        else n_state = sha_pkg::S_PAD;
                    end
                end
            end
            sha_pkg::S_PAD: begin
                if (r_fill == 6'(sha_pkg::LENGTH_POS)) begin
                    n_state = sha_pkg::S_LEN;
                end else begin
                    n_win  = {r_win[503:0], 8'h00};
                    n_fill = r_fill + 6'd1;
                    if (r_fill == 6'(sha_pkg::BLOCK_BYTES - 1)) begin
                        n_v     = r_chain;
                        n_round = '0;
                        n_state = sha_pkg::S_ROUND;
                    end
                end
            end
            sha_pkg::S_LEN: begin
                n_win  = {r_win[503:0], 8'(r_bitlen >> (6'd56 - {w_lidx, 3'b000}))};
                n_fill = r_fill + 6'd1;
                if (r_fill == 6'(sha_pkg::BLOCK_BYTES - 1)) begin
                    n_v     = r_chain;
                    n_round = '0;
                    n_final = 1'b1;
                    n_state = sha_pkg::S_ROUND;
                end
            end
            sha_pkg::S_ROUND: begin
                n_v[7] = r_v[6];
                n_v[6] = r_v[5];
                n_v[5] = r_v[4];
                n_v[4] = r_v[3] + w_t1;
                n_v[3] = r_v[2];
                n_v[2] = r_v[1];
                n_v[1] = r_v[0];
                n_v[0] = w_t1 + w_t2;
                n_win  = {r_win[479:0], w_wnew};
                n_round = r_round + 8'd1;
                if (r_round == w_eff - 8'd1) n_state = sha_pkg::S_ADD;
            end
            sha_pkg::S_ADD: begin
                for (int k = 0; k < 8; k++) n_chain[k] = r_chain[k] + r_v[k];
                n_oidx = '0;
                if (r_final) begin
                    if (w_el == 6'd0) begin
                        for (int k = 0; k < 8; k++) begin
                            n_chain[k] = sha_pkg::f_iv(1'b1, 3'(k));
                        end
                        n_bitlen = '0;
                        n_ovf    = 1'b0;
                        n_state  = sha_pkg::S_IDLE;
                    end else begin
                        n_state = sha_pkg::S_OUT;
                    end
                end else if (r_ret_pad) begin
                    n_state = sha_pkg::S_PAD;
                end else begin
                    n_state = sha_pkg::S_IDLE;
                end
            end
            sha_pkg::S_OUT: begin
                if (!r_ov || i_ready) begin
                    n_ov     = 1'b1;
                    n_obyte  = 8'(w_word >> (5'd24 - {r_oidx[1:0], 3'b000}));
                    n_oindex = r_oidx[4:0];
                    n_olast  = (r_oidx + 6'd1 == w_el);
                    n_oovf   = r_ovf;
                    n_oidx   = r_oidx + 6'd1;
                    if (r_oidx + 6'd1 == w_el) begin
                        for (int k = 0; k < 8; k++) begin
                            n_chain[k] = sha_pkg::f_iv(w_el <= 6'(sha_pkg::SHA224_LIMIT), 3'(k));
                        end
                        n_bitlen = '0;
                        n_ovf    = 1'b0;
                        n_state  = sha_pkg::S_IDLE;
                    end
                end
            end
            default: n_state = sha_pkg::S_IDLE;
        endcase

        if (i_cfg.we) begin
            if (i_cfg.index == sha_pkg::CFG_ROUND_COUNT) begin
                n_rc = i_cfg.data;
            end else if (i_cfg.index == sha_pkg::CFG_DIGEST_BYTES) begin
                n_db = i_cfg.data[5:0];
                if (r_bitlen == '0 && r_fill == '0 && !r_ovf) begin
                    for (int k = 0; k < 8; k++) begin
                        n_chain[k] = sha_pkg::f_iv(w_new_el <= 6'(sha_pkg::SHA224_LIMIT), 3'(k));
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_win    <= n_win;
        r_v      <= n_v;
        r_round  <= n_round;
        r_oidx   <= n_oidx;
        r_final  <= n_final;
        r_ret_pad <= n_ret_pad;
        r_obyte  <= n_obyte;
        r_oindex <= n_oindex;
        r_olast  <= n_olast;
        r_oovf   <= n_oovf;
        if (!i_rst_n) begin
            r_state  <= sha_pkg::S_IDLE;
            r_rc     <= 8'(sha_pkg::ROUND_CNT_DFLT);
            r_db     <= 6'(sha_pkg::DIGEST_MAX);
            r_fill   <= '0;
            r_bitlen <= '0;
            r_ovf    <= 1'b0;
            r_ov     <= 1'b0;
            for (int k = 0; k < 8; k++) r_chain[k] <= sha_pkg::f_iv(1'b0, 3'(k));
        end else begin
            r_state  <= n_state;
            r_rc     <= n_rc;
            r_db     <= n_db;
            r_fill   <= n_fill;
            r_bitlen <= n_bitlen;
            r_ovf    <= n_ovf;
            r_ov     <= n_ov;
            r_chain  <= n_chain;
        end
    end

endmodule

[rtl/sha256_hash_engine.sv]
// channel   | handshake          | payload
// request   | i_valid / o_ready  | i_command, i_data_byte
// digest    | o_valid / i_ready  | o_digest_byte, o_byte_index, o_last_byte, o_length_overflow
// config    | i_cfg_we           | i_cfg_index, i_cfg_data
// Data bytes are absorbed from the request queue; the 64th byte of a block starts the
// one-round-per-cycle compressor, which runs the effective round count (64 by default).
// Finish pads one byte a cycle up to the length field, then compresses one or two
// blocks and emits one digest byte per cycle while the consumer takes them.
// A four-entry request queue absorbs input while the compressor runs.
// Reset is synchronous, active low; no clearing pass is needed.
`include "assert_macros.svh"

module sha256_hash_engine (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_command,
    input  logic [7:0] i_data_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_digest_byte,
    output logic [4:0] o_byte_index,
    output logic       o_last_byte,
    output logic       o_length_overflow,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    sha_pkg::t_req    w_in_req;
    sha_pkg::t_req    w_req;
    sha_pkg::t_cfg_wr w_cfg;
    logic             w_req_valid;
    logic             w_pop;

    assign w_in_req = '{command: i_command, data_byte: i_data_byte};
    assign w_cfg    = '{we: i_cfg_we, index: i_cfg_index, data: i_cfg_data};

    sha_req_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_valid),
        .i_req       (w_in_req),
        .o_not_full  (o_ready),
        .i_pop       (w_pop),
        .o_req_valid (w_req_valid),
        .o_req       (w_req)
    );

    sha_core u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_req_valid       (w_req_valid),
        .i_req             (w_req),
        .o_pop             (w_pop),
        .i_cfg             (w_cfg),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_digest_byte     (o_digest_byte),
        .o_byte_index      (o_byte_index),
        .o_last_byte       (o_last_byte),
        .o_length_overflow (o_length_overflow)
    );

    `SHA_ASSERT_NR(a_reset_clear, i_clk, !i_rst_n |=> !o_valid && o_ready, "reset state")
    `SHA_ASSERT(a_gap_after_last, i_clk, i_rst_n, o_valid && i_ready && o_last_byte |=> !o_valid, "digest after last")
    `SHA_ASSERT(a_index_step, i_clk, i_rst_n, o_valid && i_ready && !o_last_byte |=> o_valid && (o_byte_index == 5'($past(o_byte_index) + 5'd1)), "byte index step")

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

    localparam int SETTLE_CYCLES = 700;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [7:0] digest_byte;
        logic [4:0] byte_index;
        logic       last_byte;
        logic       length_overflow;
    } t_digest_out;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic       i_command;
    logic [7:0] i_data_byte;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_digest_byte;
    logic [4:0] o_byte_index;
    logic       o_last_byte;
    logic       o_length_overflow;
    logic       i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [7:0] i_cfg_data;

    sha256_hash_engine DUT (.*);

    // hash model state
    logic [31:0] k_table [0:127] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B, 32'h59F111F1,
        32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786,
        32'h0FC19DC6, 32'h240CA1CC, 32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
        32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85, 32'hA2BFE8A1, 32'hA81A664B,
        32'hC24B8B70, 32'hC76C51A3, 32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A,
        32'h5B9CCA4F, 32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2, 32'hCA273ECE, 32'hD186B8C7,
        32'hEADA7DD6, 32'hF57D4F7F, 32'h06F067AA, 32'h0A637DC5, 32'h113F9804, 32'h1B710B35,
        32'h28DB77F5, 32'h32CAAB7B, 32'h3C9EBE0A, 32'h431D67C4, 32'h4CC5D4BE, 32'h597F299C,
        32'h5FCB6FAB, 32'h6C44198C, 32'h7BA0EA2D, 32'h7EABF2D0, 32'h8DBE8D03, 32'h90BB1721,
        32'h99A2AD45, 32'h9F86E289, 32'hA84C4472, 32'hB3DF34FC, 32'hB99BB8D7, 32'hBC76CBAB,
        32'hC226A69A, 32'hD304F19A, 32'hDE1BE20A, 32'hE39BB437, 32'hEE84927C, 32'hF3EDD277,
        32'hFBFDFE53, 32'h0BEE2C7A, 32'h0E90181C, 32'h25F57204, 32'h2DA45582, 32'h3A52C34C,
        32'h41DC0172, 32'h495796FC, 32'h4BD31FC6, 32'h533CDE21, 32'h5F7ABFE3, 32'h66C206B3,
        32'h6DFCC6BC, 32'h7062F20F, 32'h778D5127, 32'h7EABA3CC, 32'h8363ECCC, 32'h85BE1C25,
        32'h93C04028, 32'h9F4A205F, 32'hA1953565, 32'hA627BB0F, 32'hACFA8089, 32'hB3C29B23,
        32'hB602F6FA, 32'hC36CEE0A, 32'hC7DC81EE, 32'hCE7B8471, 32'hD740288C, 32'hE21DBA7A,
        32'hEABBFF66, 32'hF56A9E60
    };
    logic [31:0] iv256 [0:7] = '{32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
                                 32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};
    logic [31:0] iv224 [0:7] = '{32'hC1059ED8, 32'h367CD507, 32'h3070DD17, 32'hF70E5939,
                                 32'hFFC00B31, 32'h68581511, 32'h64F98FA7, 32'hBEFA4FA4};

    logic [31:0] chain [0:7];
    logic [7:0]  blk_bytes [0:63];
    logic [31:0] sched [0:127];
    int          fill;
    logic [63:0] bit_len;
    logic        len_ovf;
    logic [7:0]  rounds_reg;
    logic [5:0]  dbytes_reg;

    t_digest_out digest_q [$];
    int          fail_cnt;
    int          send_idle_pct;
    int          rx_stall_pct;
    int          rx_hold;
    int          cycle_cnt;

    function automatic logic [31:0] rotr32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic int digest_len();
        return (dbytes_reg > 6'd32) ? 32 : int'(dbytes_reg);
    endfunction

    function automatic void load_chain_iv();
        for (int i = 0; i < 8; i++)
            chain[i] = (digest_len() > sha_pkg::SHA224_LIMIT) ? iv256[i] : iv224[i];
    endfunction

    function automatic void start_msg();
        fill = 0;
        bit_len = '0;
        len_ovf = 1'b0;
        load_chain_iv();
    endfunction

    function automatic void compress_block();
        logic [31:0] v [0:7];
        logic [31:0] t1, t2, ch, mj, s0, s1;
        int r;
        r = (rounds_reg == 0) ? sha_pkg::ROUND_CNT_DFLT :
            ((rounds_reg > sha_pkg::ROUND_CNT_CAP) ? sha_pkg::ROUND_CNT_CAP : int'(rounds_reg));
        for (int i = 0; i < 16; i++)
            sched[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
        for (int i = 16; i < r; i++) begin
            s0 = rotr32(sched[i-15], 7) ^ rotr32(sched[i-15], 18) ^ (sched[i-15] >> 3);
            s1 = rotr32(sched[i-2], 17) ^ rotr32(sched[i-2], 19) ^ (sched[i-2] >> 10);
            sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
        end
        for (int i = 0; i < 8; i++) v[i] = chain[i];
        for (int i = 0; i < r; i++) begin
            ch = v[6] ^ (v[4] & (v[5] ^ v[6]));
            mj = (v[0] & v[1]) | (v[2] & (v[0] | v[1]));
            t1 = v[7] + (rotr32(v[4], 6) ^ rotr32(v[4], 11) ^ rotr32(v[4], 25)) + ch
                 + k_table[i] + sched[i];
            t2 = (rotr32(v[0], 2) ^ rotr32(v[0], 13) ^ rotr32(v[0], 22)) + mj;
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
    endfunction

    function automatic void hash_request(logic cmd, logic [7:0] d);
        t_digest_out e;
        int n;
        logic [31:0] w;
        if (cmd == sha_pkg::CMD_ABSORB) begin
            bit_len = bit_len + 64'd8;
            if (bit_len < 64'd8) len_ovf = 1'b1;
            blk_bytes[fill] = d;
            fill++;
            if (fill == sha_pkg::BLOCK_BYTES) begin
                compress_block();
                fill = 0;
            end
            return;
        end
        blk_bytes[fill] = sha_pkg::PAD_BYTE;
        fill++;
        if (fill > sha_pkg::LENGTH_POS) begin
            while (fill < sha_pkg::BLOCK_BYTES) begin blk_bytes[fill] = 8'h00; fill++; end
            compress_block();
            fill = 0;
        end
        while (fill < sha_pkg::LENGTH_POS) begin blk_bytes[fill] = 8'h00; fill++; end
        for (int i = 0; i < 8; i++) blk_bytes[sha_pkg::LENGTH_POS+i] = bit_len[63-8*i -: 8];
        compress_block();
        n = digest_len();
        for (int i = 0; i < n; i++) begin
            w = chain[i/4];
            e.digest_byte = w[31-8*(i%4) -: 8];
            e.byte_index = 5'(i);
            e.last_byte = (i + 1 == n);
            e.length_overflow = len_ovf;
            digest_q.push_back(e);
        end
        start_msg();
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            i_ready = 1'b0;
            rx_hold--;
        end else begin
            i_ready = ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_digest_out e;
        if (i_rst_n && o_valid && i_ready) begin
            if (digest_q.size() == 0) begin
                $error("unexpected digest byte %h index %0d", o_digest_byte, o_byte_index);
                fail_cnt++;
            end else begin
                e = digest_q.pop_front();
                if (o_digest_byte !== e.digest_byte) begin
                    $error("digest_byte exp %h got %h", e.digest_byte, o_digest_byte);
                    fail_cnt++;
                end
                if (o_byte_index !== e.byte_index) begin
                    $error("byte_index exp %0d got %0d", e.byte_index, o_byte_index);
                    fail_cnt++;
                end
                if (o_last_byte !== e.last_byte) begin
                    $error("last_byte exp %b got %b", e.last_byte, o_last_byte);
                    fail_cnt++;
                end
                if (o_length_overflow !== e.length_overflow) begin
                    $error("length_overflow exp %b got %b", e.length_overflow,
                           o_length_overflow);
                    fail_cnt++;
                end
            end
        end
    end

    task automatic send_request(logic cmd, logic [7:0] d);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            i_command = logic'($urandom);
            i_data_byte = 8'($urandom);
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_command = cmd;
        i_data_byte = d;
        do @(posedge i_clk); while (!o_ready);
        hash_request(cmd, d);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        wait (digest_q.size() == 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [7:0] val);
        drain();
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        if (idx == sha_pkg::CFG_ROUND_COUNT) begin
            rounds_reg = val;
        end else if (idx == sha_pkg::CFG_DIGEST_BYTES) begin
            dbytes_reg = val[5:0];
            if (bit_len == 0 && fill == 0 && !len_ovf) load_chain_iv();
        end
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic send_message(int len);
        for (int i = 0; i < len; i++) send_request(sha_pkg::CMD_ABSORB, 8'($urandom));
        send_request(sha_pkg::CMD_FINISH, 8'($urandom));
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        rx_stall_pct = 0;
        send_request(sha_pkg::CMD_FINISH, 8'h00);
        send_request(sha_pkg::CMD_ABSORB, 8'h00);
        send_request(sha_pkg::CMD_ABSORB, 8'hFF);
        send_request(sha_pkg::CMD_FINISH, 8'hFF);
        write_cfg(sha_pkg::CFG_ROUND_COUNT, 8'd0);
        send_message(1);
        write_cfg(sha_pkg::CFG_ROUND_COUNT, 8'd8);
        send_message(2);
        write_cfg(sha_pkg::CFG_ROUND_COUNT, 8'd255);
        send_message(0);
        write_cfg(sha_pkg::CFG_ROUND_COUNT, 8'd128);
        write_cfg(sha_pkg::CFG_DIGEST_BYTES, 8'd28);
        send_message(1);
        write_cfg(sha_pkg::CFG_DIGEST_BYTES, 8'd0);
        send_message(1);
        write_cfg(sha_pkg::CFG_DIGEST_BYTES, 8'h7F);
        send_message(0);
        write_cfg(sha_pkg::CFG_DIGEST_BYTES, 8'd1);
        send_request(sha_pkg::CMD_ABSORB, 8'hA5);
        // mid-message length change keeps the old start values
        write_cfg(sha_pkg::CFG_DIGEST_BYTES, 8'd29);
        send_request(sha_pkg::CMD_FINISH, 8'h00);
        write_cfg(sha_pkg::CFG_ROUND_COUNT, 8'd1);
        send_message(0);
    endtask

    task automatic test_two_block_pad();
        send_idle_pct = 0;
        rx_stall_pct = 0;
        write_cfg(sha_pkg::CFG_ROUND_COUNT, 8'd64);
        write_cfg(sha_pkg::CFG_DIGEST_BYTES, 8'd32);
        // padding spills into a second block
        send_message(57);
    endtask

    task automatic test_random(int idle_pct, int stall_pct, int items);
        int sent;
        int len;
        send_idle_pct = idle_pct;
        rx_stall_pct = stall_pct;
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(3) == 0) begin
                drain();
                write_cfg(sha_pkg::CFG_ROUND_COUNT, ($urandom_range(3) == 0) ?
                          8'($urandom) : 8'($urandom_range(60, 70)));
                write_cfg(sha_pkg::CFG_DIGEST_BYTES, 8'($urandom_range(0, 40)));
            end
            len = $urandom_range(0, 6);
            send_message(len);
            sent += len + 1;
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        rx_stall_pct = 0;
        write_cfg(sha_pkg::CFG_ROUND_COUNT, 8'd16);
        write_cfg(sha_pkg::CFG_DIGEST_BYTES, 8'd32);
        @(negedge i_clk);
        rx_hold = 400;
        for (int i = 0; i < 4; i++) send_message(i);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_command = sha_pkg::CMD_ABSORB;
        i_data_byte = 8'h00;
        i_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = sha_pkg::CFG_ROUND_COUNT;
        i_cfg_data = 8'h00;
        fail_cnt = 0;
        cycle_cnt = 0;
        rx_hold = 0;
        send_idle_pct = 0;
        rx_stall_pct = 0;
        rounds_reg = 8'd64;
        dbytes_reg = 6'd32;
        for (int i = 0; i < 64; i++) blk_bytes[i] = 8'h00;
        for (int i = 0; i < 128; i++) sched[i] = '0;
        start_msg();
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_two_block_pad();
        test_random(0, 0, 6);
        test_random(46, 0, 6);
        test_random(0, 46, 6);
        test_random(35, 35, 6);
        test_backpressure();

        drain();
        if (fail_cnt == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/sha_pkg.sv
rtl/sha_req_fifo.sv
rtl/sha_core.sv
rtl/sha256_hash_engine.sv
tb/tb_top.sv
